>>> hdl/bkvm_pkg.sv
// ----------------------------------------------------------------------------
// bkvm_pkg
// Shared codes and types of the bucketed key/value map.
// ----------------------------------------------------------------------------
package bkvm_pkg;

	typedef enum logic [1:0] {
		ACT_PUT    = 2'd0,
		ACT_GET    = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	typedef struct packed {
		logic hit;
		logic full;
	} row_stat_t;

endpackage

>>> hdl/bucketed_key_value_map.sv
// ----------------------------------------------------------------------------
// bucketed_key_value_map
// Key/value map with fixed-size buckets held in one wide row memory.
// ----------------------------------------------------------------------------
// Each beat on s is a put, get or remove (s_tuser) of a key and value (s_tdata);
// each gives one result beat on m with the read value in m_tdata and the hit
// and bucket full flags in m_tuser. The upper key bits pick a bucket row of
// BUCKET_SLOTS slots. The accept cycle reads the bucket row from the
// synchronous memory; in the look state that follows, all slots are compared
// and the row is written back once the result register is free, and s_tready
// stays low until then; the result register lets the next item enter while a
// result waits on m. After reset a clearing pass writes every row, all
// 2^(KEY_BITS-BUCKET_SHIFT) rows (1024 by default), with s_tready low.
module bucketed_key_value_map #(
	parameter int KEY_BITS     = 20,
	parameter int BUCKET_SHIFT = 10,
	parameter int BUCKET_SLOTS = 16,
	parameter int VALUE_BITS   = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// key, value
	input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  logic [1:0]                              s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// read_value
	output logic [((VALUE_BITS+7)/8)*8-1:0]         m_tdata,
	// hit, bucket_full
	output logic [1:0]                              m_tuser
);

	localparam int BKT_W   = KEY_BITS - BUCKET_SHIFT;
	localparam int NUM_BKT = 1 << BKT_W;
	localparam int TAG_W   = (BUCKET_SHIFT > 0) ? BUCKET_SHIFT : 1;
	localparam int ROW_W   = BUCKET_SLOTS * (1 + TAG_W + VALUE_BITS);
	localparam int MDATA_W = ((VALUE_BITS+7)/8)*8;
	localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << BUCKET_SHIFT) - 64'd1);
	localparam logic [BKT_W-1:0] CLR_LAST = BKT_W'(NUM_BKT - 1);

	bkvm_pkg::state_t state_q;
	logic [BKT_W-1:0] clr_q;

	logic [1:0]            action_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	logic [ROW_W-1:0] mem [NUM_BKT];
	logic [ROW_W-1:0] rd_q;

	logic                  m_tvalid_q;
	logic [VALUE_BITS-1:0] rdval_q;
	logic                  hit_q;
	logic                  full_q;

	logic                  s_fire;
	logic                  fire;
	logic                  clearing;
	logic                  wr_en;
	logic [BKT_W-1:0]      wr_addr;
	logic [ROW_W-1:0]      wr_data;
	logic [BKT_W-1:0]      rd_addr;
	logic [BKT_W-1:0]      bkt_q;
	logic [KEY_BITS-1:0]   s_key;
	logic [TAG_W-1:0]      tag;
	logic [ROW_W-1:0]      new_row;
	logic [VALUE_BITS-1:0] read_value;
	bkvm_pkg::row_stat_t   stat;

	assign s_tready = (state_q == bkvm_pkg::ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign clearing = (state_q == bkvm_pkg::ST_CLEAR);
	assign fire     = (state_q == bkvm_pkg::ST_LOOK) && (!m_tvalid_q || m_tready);

	assign s_key   = s_tdata[KEY_BITS-1:0];
	assign bkt_q   = key_q[KEY_BITS-1:BUCKET_SHIFT];
	assign rd_addr = s_tready ? s_key[KEY_BITS-1:BUCKET_SHIFT] : bkt_q;
	assign tag     = key_q[TAG_W-1:0] & TAG_MASK;

	assign wr_en   = clearing || fire;
	assign wr_addr = clearing ? clr_q : bkt_q;
	assign wr_data = clearing ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	bkvm_row_update #(
		.SLOTS      (BUCKET_SLOTS),
		.TAG_W      (TAG_W),
		.VALUE_BITS (VALUE_BITS)
	) u_row (
		.row        (rd_q),
		.action     (action_q),
		.tag        (tag),
		.value      (value_q),
		.new_row    (new_row),
		.read_value (read_value),
		.stat       (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bkvm_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				bkvm_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= bkvm_pkg::ST_IDLE;
					end
				end
				bkvm_pkg::ST_IDLE: begin
					if (s_fire) begin
						state_q <= bkvm_pkg::ST_LOOK;
					end
				end
				bkvm_pkg::ST_LOOK: begin
					if (fire) begin
						state_q <= bkvm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bkvm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			action_q <= s_tuser;
			key_q    <= s_key;
			value_q  <= s_tdata[KEY_BITS +: VALUE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rdval_q <= read_value;
			hit_q   <= stat.hit;
			full_q  <= stat.full;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = MDATA_W'(rdval_q);
	assign m_tuser  = {full_q, hit_q};

endmodule

>>> hdl/bkvm_row_update.sv
// ----------------------------------------------------------------------------
// bkvm_row_update
// Compares a key tag against every slot of one bucket row and builds the
// row to write back, the read value and the hit and full flags.
// ----------------------------------------------------------------------------
module bkvm_row_update #(
	parameter int SLOTS      = 16,
	parameter int TAG_W      = 10,
	parameter int VALUE_BITS = 32
) (
	input  logic [SLOTS*(1+TAG_W+VALUE_BITS)-1:0] row,
	input  logic [1:0]                             action,
	input  logic [TAG_W-1:0]                       tag,
	input  logic [VALUE_BITS-1:0]                  value,
	output logic [SLOTS*(1+TAG_W+VALUE_BITS)-1:0] new_row,
	output logic [VALUE_BITS-1:0]                  read_value,
	output bkvm_pkg::row_stat_t                    stat
);

	localparam int SLOT_W = 1 + TAG_W + VALUE_BITS;

	logic [SLOTS-1:0]      valid;
	logic [SLOTS-1:0]      match;
	logic [SLOTS-1:0]      inv;
	logic [SLOTS-1:0]      free_oh;
	logic [VALUE_BITS-1:0] rd;
	logic                  is_put;
	logic                  is_get;
	logic                  is_rem;
	logic                  any_hit;
	logic                  free_any;

	assign is_put = (action == bkvm_pkg::ACT_PUT);
	assign is_get = (action == bkvm_pkg::ACT_GET);
	assign is_rem = (action == bkvm_pkg::ACT_REMOVE);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			valid[i] = row[i*SLOT_W];
			match[i] = row[i*SLOT_W] && (row[i*SLOT_W+1 +: TAG_W] == tag);
		end
	end

	// lowest free slot, one-hot
	assign inv      = ~valid;
	assign free_oh  = inv & (~inv + SLOTS'(1));
	assign free_any = |inv;
	assign any_hit  = |match;

	always_comb begin
		rd = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match[i]) begin
				rd = rd | row[i*SLOT_W+1+TAG_W +: VALUE_BITS];
			end
		end
	end

	always_comb begin
		new_row = row;
		for (int i = 0; i < SLOTS; i++) begin
			if (is_put && any_hit && match[i]) begin
				new_row[i*SLOT_W+1+TAG_W +: VALUE_BITS] = value;
			end else if (is_put && !any_hit && free_oh[i]) begin
				new_row[i*SLOT_W +: SLOT_W] = {value, tag, 1'b1};
			end else if (is_rem && match[i]) begin
				new_row[i*SLOT_W] = 1'b0;
			end
		end
	end

	assign read_value = (is_get && any_hit) ? rd : '1;
	assign stat.hit   = (is_put || is_get || is_rem) && any_hit;
	assign stat.full  = is_put && !any_hit && !free_any;

endmodule

>>> verif/bkvm_checker.sv
// ----------------------------------------------------------------------------
// bkvm_checker
// Watches both streams of the bucketed key/value map and keeps its own copy
// of every bucket. Each accepted operation beat is applied to that copy to
// work out its result. Each result beat is compared field by field with the
// oldest result still due.
// ----------------------------------------------------------------------------
module bkvm_checker #(
	parameter int KEY_BITS     = 20,
	parameter int BUCKET_SHIFT = 10,
	parameter int BUCKET_SLOTS = 16,
	parameter int VALUE_BITS   = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	input  logic                                     s_tready,
	// key, value
	input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  logic [1:0]                               s_tuser,
	input  logic                                     m_tvalid,
	input  logic                                     m_tready,
	// read_value
	input  logic [((VALUE_BITS+7)/8)*8-1:0]          m_tdata,
	// hit, bucket_full
	input  logic [1:0]                               m_tuser,
	output int                                       mismatches,
	output int                                       results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BUCKETS = 1 << (KEY_BITS - BUCKET_SHIFT);

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  bucket_full;
	} map_result_t;

	bit                    slot_vld [NUM_BUCKETS][BUCKET_SLOTS];
	logic [KEY_BITS-1:0]   slot_key [NUM_BUCKETS][BUCKET_SLOTS];
	logic [VALUE_BITS-1:0] slot_val [NUM_BUCKETS][BUCKET_SLOTS];
	map_result_t           due_results [$];

	function automatic map_result_t apply_map_op(logic [1:0] act, logic [KEY_BITS-1:0] k,
			logic [VALUE_BITS-1:0] v);
		map_result_t res;
		int          b;
		int          found;
		int          free_idx;
		res.hit         = 1'b0;
		res.read_value  = '1;
		res.bucket_full = 1'b0;
		b        = int'(k >> BUCKET_SHIFT);
		found    = -1;
		free_idx = -1;
		for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
			if (slot_vld[b][i] && slot_key[b][i] == k)
				found = i;
			if (!slot_vld[b][i])
				free_idx = i;
		end
		case (act)
			bkvm_pkg::ACT_PUT: begin
				res.hit = (found >= 0);
				if (found >= 0) begin
					slot_val[b][found] = v;
				end else if (free_idx < 0) begin
					res.bucket_full = 1'b1;
				end else begin
					slot_vld[b][free_idx] = 1'b1;
					slot_key[b][free_idx] = k;
					slot_val[b][free_idx] = v;
				end
			end
			bkvm_pkg::ACT_GET: begin
				res.hit = (found >= 0);
				if (found >= 0)
					res.read_value = slot_val[b][found];
			end
			bkvm_pkg::ACT_REMOVE: begin
				res.hit = (found >= 0);
				if (found >= 0)
					slot_vld[b][found] = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch %s: expected %0h actual %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		map_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++)
				for (int j = 0; j < BUCKET_SLOTS; j++)
					slot_vld[i][j] = 1'b0;
			due_results.delete();
			mismatches  = 0;
			results_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					note_mismatch("unexpected result beat", '0, 64'(m_tdata));
				end else begin
					want = due_results.pop_front();
					if (m_tuser[0] !== want.hit)
						note_mismatch("hit", 64'(want.hit), 64'(m_tuser[0]));
					if (m_tdata[VALUE_BITS-1:0] !== want.read_value)
						note_mismatch("read_value", 64'(want.read_value),
							64'(m_tdata[VALUE_BITS-1:0]));
					if (m_tuser[1] !== want.bucket_full)
						note_mismatch("bucket_full", 64'(want.bucket_full), 64'(m_tuser[1]));
				end
			end
			if (s_tvalid && s_tready)
				due_results.insert(due_results.size(),
					apply_map_op(s_tuser, s_tdata[KEY_BITS-1:0],
					s_tdata[KEY_BITS +: VALUE_BITS]));
			results_due = due_results.size();
		end
	end

endmodule

>>> verif/bucketed_key_value_map_tb.sv
// ----------------------------------------------------------------------------
// bucketed_key_value_map_tb
// Drives put, get and remove beats into the key/value map and checks results.
// A short directed run covers misses, overwrites, field extremes, the spare
// action code and a bucket that overflows; random phases then hammer a few
// hot buckets so that they fill, overflow and drain. Both sides idle at
// random and the receiver once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module bucketed_key_value_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_BITS       = 20;
	localparam int BUCKET_SHIFT   = 10;
	localparam int BUCKET_SLOTS   = 16;
	localparam int VALUE_BITS     = 32;
	localparam int SD_W           = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int MD_W           = ((VALUE_BITS + 7) / 8) * 8;
	localparam int NUM_BUCKETS    = 1 << (KEY_BITS - BUCKET_SHIFT);
	localparam int NUM_PHASES     = 6;
	localparam int PHASE_ITEMS    = 188;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [SD_W-1:0] s_tdata;
	logic [1:0]      s_tuser;
	logic            m_tvalid;
	logic            m_tready;
	logic [MD_W-1:0] m_tdata;
	logic [1:0]      m_tuser;
	int              mismatches;
	int              results_due;
	bit              calm = 1'b0;
	bit              hold_req = 1'b0;
	int              quiet_cycles = 0;

	always #5ns clk = ~clk;

	bucketed_key_value_map #(
		.KEY_BITS    (KEY_BITS),
		.BUCKET_SHIFT(BUCKET_SHIFT),
		.BUCKET_SLOTS(BUCKET_SLOTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	bkvm_checker #(
		.KEY_BITS    (KEY_BITS),
		.BUCKET_SHIFT(BUCKET_SHIFT),
		.BUCKET_SLOTS(BUCKET_SLOTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.results_due(results_due)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic issue_op(logic [1:0] act, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= SD_W'({v, k});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[bucketed_key_value_map] ERROR");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		stall    = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin : op_source
		int               hot [4];
		int               put_pct;
		int               r;
		logic [1:0]       act;
		logic [KEY_BITS-1:0] k;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = bkvm_pkg::ACT_PUT;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// misses, overwrite and removal at the key and value extremes
		issue_op(bkvm_pkg::ACT_GET, '1, VALUE_BITS'($urandom));
		issue_op(bkvm_pkg::ACT_REMOVE, '0, VALUE_BITS'($urandom));
		issue_op(bkvm_pkg::ACT_PUT, '1, {1'b0, {(VALUE_BITS-1){1'b1}}});
		issue_op(bkvm_pkg::ACT_PUT, '1, {1'b1, {(VALUE_BITS-1){1'b0}}});
		issue_op(bkvm_pkg::ACT_GET, '1, '0);
		issue_op(bkvm_pkg::ACT_REMOVE, '1, '1);
		issue_op(bkvm_pkg::ACT_GET, '1, '0);
		issue_op(ACT_SPARE, KEY_BITS'($urandom), VALUE_BITS'($urandom));
		// fill bucket zero, overflow it, free one slot and retry
		for (int i = 0; i < BUCKET_SLOTS; i++)
			issue_op(bkvm_pkg::ACT_PUT, KEY_BITS'(i), (i == 0) ? '1 : VALUE_BITS'($urandom));
		issue_op(bkvm_pkg::ACT_PUT, KEY_BITS'(BUCKET_SLOTS), VALUE_BITS'($urandom));
		issue_op(bkvm_pkg::ACT_REMOVE, KEY_BITS'(5), '0);
		issue_op(bkvm_pkg::ACT_PUT, KEY_BITS'(BUCKET_SLOTS), VALUE_BITS'($urandom));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			calm = (ph == 3);
			case (ph)
				0: put_pct = 55;
				1: put_pct = 45;
				2: put_pct = 60;
				3: put_pct = 35;
				4: put_pct = 50;
				default: put_pct = 30;
			endcase
			foreach (hot[i])
				hot[i] = $urandom_range(0, NUM_BUCKETS - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 50)
					hold_req = 1'b1;
				r = $urandom_range(0, 99);
				if (r < put_pct)
					act = bkvm_pkg::ACT_PUT;
				else if (r < put_pct + 35)
					act = bkvm_pkg::ACT_GET;
				else if (r < 98)
					act = bkvm_pkg::ACT_REMOVE;
				else
					act = ACT_SPARE;
				if ($urandom_range(0, 99) < 15)
					k = KEY_BITS'($urandom);
				else
					k = (KEY_BITS'(hot[$urandom_range(0, 3)]) << BUCKET_SHIFT)
						| KEY_BITS'($urandom_range(0, BUCKET_SLOTS + 7));
				issue_op(act, k, VALUE_BITS'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		wait (results_due == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("[bucketed_key_value_map] OK");
		else
			$display("[bucketed_key_value_map] ERROR");
		$finish;
	end

endmodule
